@@ design/tcw_pkg.sv @@
// Shared types, constants and codes for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned COL_W   = $clog2(COLUMNS);

  // Fixed field widths.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned IN_ADDR_W = 11;
  localparam int unsigned CURSOR_W  = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;

  // Cell and character constants.
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, BLANK_CHAR};

  // Address landmarks.
  localparam addr_t LAST_CELL      = addr_t'(CELLS - 1);
  localparam addr_t LAST_ROW_START = addr_t'(CELLS - COLUMNS);
  localparam addr_t MOVE_LAST      = addr_t'(CELLS - COLUMNS - 1);
  localparam addr_t ROW_STEP       = addr_t'(COLUMNS);
  localparam addr_t ROW_STEP_NEXT  = addr_t'(COLUMNS + 1);
  localparam col_t  LAST_COL       = col_t'(COLUMNS - 1);

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL_PRIME,
    ST_SCROLL_MOVE,
    ST_SCROLL_BLANK,
    ST_FINISH
  } state_e;

  // Input beat.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [CHAR_W-1:0]    char_code;
    logic [IN_ADDR_W-1:0] cell_address;
  } tcw_in_t;

  // Result beat.
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   cell_word;
    logic                scrolled;
  } tcw_out_t;

  // Cursor commands from the sequencer.
  typedef struct packed {
    logic home;
    logic advance;
    logic newline;
  } cursor_cmd_t;

  // Cursor status back to the sequencer.
  typedef struct packed {
    addr_t cursor;
    logic  at_last_row;
  } cursor_stat_t;

endpackage

@@ design/text_console_writer_top.sv @@
// Text console writer top: attribute register, screen store, cursor tracker and sequencer.
//   Put, newline without scroll, read and the unused mode: the item passes through the
//   finish state before the result strobe, and the next item may start in the strobe cycle.
//   Clear walks the store one cell per cycle on the single write port.
//   A scrolling newline moves and blanks one cell per cycle.
//   After reset the store is filled with blanks, one cell per cycle, while busy stays
//   high; the receiver cannot stall, so results never wait.
`timescale 1ns / 1ps
module text_console_writer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tcw_pkg::tcw_in_t           cmd_i,
  input  logic                       attr_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attr_wdata_i,
  output logic                       result_valid_o,
  output tcw_pkg::tcw_out_t          result_o
);

  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  tcw_pkg::cursor_cmd_t       cur_cmd;
  tcw_pkg::cursor_stat_t      cur_stat;
  logic                       ram_we;
  tcw_pkg::addr_t             ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  tcw_pkg::addr_t             ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // Attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::RESET_ATTR;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  // Screen store.
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Cursor tracking.
  tcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .stat_o (cur_stat)
  );

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .attr_i         (attr_q),
    .cur_stat_i     (cur_stat),
    .cur_cmd_o      (cur_cmd),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ design/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/tcw_cursor.sv @@
// Cursor tracker: linear position, column and start of the current row.
`timescale 1ns / 1ps
module tcw_cursor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcw_pkg::cursor_cmd_t  cmd_i,
  output tcw_pkg::cursor_stat_t stat_o
);

  tcw_pkg::addr_t cursor_q, cursor_d;
  tcw_pkg::addr_t row_start_q, row_start_d;
  tcw_pkg::col_t  col_q, col_d;
  logic           at_last_row;

  assign at_last_row = (row_start_q == tcw_pkg::LAST_ROW_START);

  // Next cursor position; the row start avoids any division by the row length.
  always_comb begin
    cursor_d    = cursor_q;
    row_start_d = row_start_q;
    col_d       = col_q;
    if (cmd_i.home) begin
      cursor_d    = '0;
      row_start_d = '0;
      col_d       = '0;
    end else if (cmd_i.advance) begin
      if (cursor_q == tcw_pkg::LAST_CELL) begin
        cursor_d    = '0;
        row_start_d = '0;
        col_d       = '0;
      end else begin
        cursor_d = cursor_q + tcw_pkg::addr_t'(1);
        if (col_q == tcw_pkg::LAST_COL) begin
          col_d       = '0;
          row_start_d = row_start_q + tcw_pkg::ROW_STEP;
        end else begin
          col_d = col_q + tcw_pkg::col_t'(1);
        end
      end
    end else if (cmd_i.newline) begin
      col_d = '0;
      if (at_last_row) begin
        // The screen scrolls, so the cursor stays at the start of the last row.
        cursor_d = row_start_q;
      end else begin
        row_start_d = row_start_q + tcw_pkg::ROW_STEP;
        cursor_d    = row_start_q + tcw_pkg::ROW_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      row_start_q <= '0;
      col_q       <= '0;
    end else begin
      cursor_q    <= cursor_d;
      row_start_q <= row_start_d;
      col_q       <= col_d;
    end
  end

  assign stat_o.cursor      = cursor_q;
  assign stat_o.at_last_row = at_last_row;

endmodule

@@ design/tcw_ctrl.sv @@
// Sequencer: drives the shared sweep counter over the screen store and forms results.
`timescale 1ns / 1ps
module tcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tcw_pkg::tcw_in_t              cmd_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    attr_i,
  input  tcw_pkg::cursor_stat_t         cur_stat_i,
  output tcw_pkg::cursor_cmd_t          cur_cmd_o,
  output logic                          ram_we_o,
  output tcw_pkg::addr_t                ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]    ram_wdata_o,
  output tcw_pkg::addr_t                ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata_i,
  output logic                          result_valid_o,
  output tcw_pkg::tcw_out_t             result_o
);

  tcw_pkg::state_e   state_q, state_d;
  tcw_pkg::addr_t    sweep_q, sweep_d;
  logic              scrolled_q, scrolled_d;
  logic              rd_hit_q, rd_hit_d;
  logic              valid_q, valid_d;
  tcw_pkg::tcw_out_t result_q, result_d;
  logic              accept;
  logic              is_newline;
  logic              rd_in_range;
  logic              sweep_last;
  logic [tcw_pkg::CELL_W-1:0] blank_cell;

  assign accept      = start && !busy;
  assign busy        = (state_q != tcw_pkg::ST_IDLE);
  assign is_newline  = (cmd_i.char_code == tcw_pkg::NEWLINE_CHAR);
  assign rd_in_range = (32'(cmd_i.cell_address) < tcw_pkg::CELLS);
  assign sweep_last  = (sweep_q == tcw_pkg::LAST_CELL);
  assign blank_cell  = {attr_i, tcw_pkg::BLANK_CHAR};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd_i.mode == tcw_pkg::MODE_PUT && is_newline && cur_stat_i.at_last_row) begin
            state_d = tcw_pkg::ST_SCROLL_PRIME;
          end else if (cmd_i.mode == tcw_pkg::MODE_CLEAR) begin
            state_d = tcw_pkg::ST_CLEAR;
          end else begin
            state_d = tcw_pkg::ST_FINISH;
          end
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (sweep_last) state_d = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_SCROLL_PRIME: begin
        state_d = tcw_pkg::ST_SCROLL_MOVE;
      end
      tcw_pkg::ST_SCROLL_MOVE: begin
        if (sweep_q == tcw_pkg::MOVE_LAST) state_d = tcw_pkg::ST_SCROLL_BLANK;
      end
      tcw_pkg::ST_SCROLL_BLANK: begin
        if (sweep_last) state_d = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_FINISH: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath control per state.
  always_comb begin
    cur_cmd_o   = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = sweep_q;
    ram_wdata_o = blank_cell;
    ram_raddr_o = '0;
    sweep_d     = sweep_q;
    scrolled_d  = scrolled_q;
    rd_hit_d    = rd_hit_q;
    valid_d     = 1'b0;
    result_d    = result_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        // Power-up fill uses the reset attribute.
        ram_we_o    = 1'b1;
        ram_wdata_o = tcw_pkg::RESET_BLANK;
        sweep_d     = sweep_last ? '0 : sweep_q + tcw_pkg::addr_t'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          scrolled_d = 1'b0;
          rd_hit_d   = 1'b0;
          case (cmd_i.mode)
            tcw_pkg::MODE_PUT: begin
              if (is_newline) begin
                cur_cmd_o.newline = 1'b1;
                scrolled_d        = cur_stat_i.at_last_row;
              end else begin
                ram_we_o          = 1'b1;
                ram_waddr_o       = cur_stat_i.cursor;
                ram_wdata_o       = {attr_i, cmd_i.char_code};
                cur_cmd_o.advance = 1'b1;
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              cur_cmd_o.home = 1'b1;
            end
            tcw_pkg::MODE_READ: begin
              rd_hit_d = rd_in_range;
              if (rd_in_range) begin
                ram_raddr_o = tcw_pkg::addr_t'(cmd_i.cell_address);
              end
            end
            default: begin
            end
          endcase
        end
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we_o = 1'b1;
        sweep_d  = sweep_last ? '0 : sweep_q + tcw_pkg::addr_t'(1);
      end
      tcw_pkg::ST_SCROLL_PRIME: begin
        // Fetch the first cell of the second row.
        ram_raddr_o = tcw_pkg::ROW_STEP;
      end
      tcw_pkg::ST_SCROLL_MOVE: begin
        // Write the cell fetched last cycle one row up and fetch the next one.
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (sweep_q != tcw_pkg::MOVE_LAST) begin
          ram_raddr_o = sweep_q + tcw_pkg::ROW_STEP_NEXT;
        end
        sweep_d = sweep_q + tcw_pkg::addr_t'(1);
      end
      tcw_pkg::ST_SCROLL_BLANK: begin
        ram_we_o = 1'b1;
        sweep_d  = sweep_last ? '0 : sweep_q + tcw_pkg::addr_t'(1);
      end
      tcw_pkg::ST_FINISH: begin
        valid_d            = 1'b1;
        result_d.cursor    = tcw_pkg::CURSOR_W'(cur_stat_i.cursor);
        result_d.cell_word = rd_hit_q ? ram_rdata_i : '0;
        result_d.scrolled  = scrolled_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcw_pkg::ST_INIT;
      sweep_q    <= '0;
      scrolled_q <= 1'b0;
      rd_hit_q   <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      scrolled_q <= scrolled_d;
      rd_hit_q   <= rd_hit_d;
      valid_q    <= valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // A result beat only follows the finish state.
  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) == tcw_pkg::ST_FINISH)
    else $error("result beat without a finished item");

  // The store is untouched while idle without a new item.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::ST_IDLE && !start) |-> !ram_we_o)
    else $error("store written while idle");

  // Every write stays inside the screen.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> 32'(ram_waddr_o) < tcw_pkg::CELLS)
    else $error("store write out of range");

  // A newline on the last row starts a scroll and flags it.
  a_newline_scrolls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.mode == tcw_pkg::MODE_PUT && is_newline && cur_stat_i.at_last_row)
      |=> (state_q == tcw_pkg::ST_SCROLL_PRIME && scrolled_q))
    else $error("newline on last row did not scroll");

endmodule
